// ===== hdl/sge_pkg.sv =====
// Shared types and constants of the speed governor Euler step block.
// Holds the item structs, register map, reset values and sequencer codes.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package sge_pkg;

    localparam int FIELD_BITS     = 32;
    localparam int CFG_INDEX_BITS = 3;

    // One input item.
    typedef struct packed {
        logic                         cmd;
        logic signed [FIELD_BITS-1:0] speed;
        logic signed [FIELD_BITS-1:0] power_setpoint;
        logic        [FIELD_BITS-2:0] step_time;
        logic signed [FIELD_BITS-1:0] init_power;
    } step_item_t;

    // One result item.
    typedef struct packed {
        logic signed [FIELD_BITS-1:0] mech_power;
        logic signed [FIELD_BITS-1:0] lag_state;
        logic                         limited;
        logic                         at_high_limit;
    } result_item_t;

    // Configuration register file contents.
    typedef struct packed {
        logic signed [FIELD_BITS-1:0] inv_t3;
        logic signed [FIELD_BITS-1:0] k_over_t3;
        logic signed [FIELD_BITS-1:0] omega_gain;
        logic signed [FIELD_BITS-1:0] inv_t1;
        logic signed [FIELD_BITS-1:0] lag_gain;
        logic signed [FIELD_BITS-1:0] p_max;
        logic signed [FIELD_BITS-1:0] p_min;
    } cfg_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_INV_T3     = 3'd0,
        CFG_K_OVER_T3  = 3'd1,
        CFG_OMEGA_GAIN = 3'd2,
        CFG_INV_T1     = 3'd3,
        CFG_LAG_GAIN   = 3'd4,
        CFG_P_MAX      = 3'd5,
        CFG_P_MIN      = 3'd6
    } cfg_idx_t;

    localparam logic signed [FIELD_BITS-1:0] RST_INV_T3     = 32'sd20971520;
    localparam logic signed [FIELD_BITS-1:0] RST_K_OVER_T3  = 32'sd349532324;
    localparam logic signed [FIELD_BITS-1:0] RST_OMEGA_GAIN = 32'sd524298486;
    localparam logic signed [FIELD_BITS-1:0] RST_INV_T1     = 32'sd10485760;
    localparam logic signed [FIELD_BITS-1:0] RST_LAG_GAIN   = -32'sd5242880;
    localparam logic signed [FIELD_BITS-1:0] RST_P_MAX      = 32'sd1048576;
    localparam logic signed [FIELD_BITS-1:0] RST_P_MIN      = 32'sd0;

    // Products in the order the sequencer issues them.
    typedef enum logic [2:0] {
        OP_PSET      = 3'd0,
        OP_PWR       = 3'd1,
        OP_LAG       = 3'd2,
        OP_ERR       = 3'd3,
        OP_LAG_ERR   = 3'd4,
        OP_LAG_DECAY = 3'd5,
        OP_DP        = 3'd6,
        OP_DX        = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_CLAMP,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/sge_cfg_regs.sv =====
// Configuration register file of the speed governor block.
// Decodes plain register writes; depends on sge_pkg.
`default_nettype none

module sge_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [sge_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [sge_pkg::FIELD_BITS-1:0]     cfg_data,
    output sge_pkg::cfg_t                           cfg
);
    import sge_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inv_t3     <= RST_INV_T3;
            cfg_reg.k_over_t3  <= RST_K_OVER_T3;
            cfg_reg.omega_gain <= RST_OMEGA_GAIN;
            cfg_reg.inv_t1     <= RST_INV_T1;
            cfg_reg.lag_gain   <= RST_LAG_GAIN;
            cfg_reg.p_max      <= RST_P_MAX;
            cfg_reg.p_min      <= RST_P_MIN;
        end
        else if (cfg_write)
        begin
            // Writes to an index beyond the map are dropped.
            unique case (cfg_idx_t'(cfg_index))
                CFG_INV_T3:     cfg_reg.inv_t3     <= cfg_data;
                CFG_K_OVER_T3:  cfg_reg.k_over_t3  <= cfg_data;
                CFG_OMEGA_GAIN: cfg_reg.omega_gain <= cfg_data;
                CFG_INV_T1:     cfg_reg.inv_t1     <= cfg_data;
                CFG_LAG_GAIN:   cfg_reg.lag_gain   <= cfg_data;
                CFG_P_MAX:      cfg_reg.p_max      <= cfg_data;
                CFG_P_MIN:      cfg_reg.p_min      <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hdl/sge_serial_mul.sv =====
// Bit-serial fixed-point multiplier: one multiplier bit per cycle on magnitudes,
// then truncation toward zero and saturation to the word range. Uses sge_pkg.
`default_nettype none

module sge_serial_mul #(
    parameter int OP_W      = 32,
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 20
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic signed [OP_W-1:0]      a,
    input  wire logic signed [OP_W-1:0]      b,
    output logic                             done,
    output logic signed [WORD_BITS-1:0]      result
);
    import sge_pkg::*;

    localparam int CNT_W = $clog2(OP_W);
    localparam int QW    = 2 * OP_W - FRAC_BITS;

    logic [OP_W-1:0]          ma_reg;
    logic [OP_W-1:0]          mb_reg;
    logic [2*OP_W-1:0]        acc_reg;
    logic                     neg_reg;
    logic                     run_reg;
    logic                     fin_reg;
    logic                     done_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [WORD_BITS-1:0] result_reg;

    logic [OP_W-1:0]          a_mag;
    logic [OP_W-1:0]          b_mag;
    logic [OP_W:0]            partial;
    logic [QW-1:0]            scaled;
    logic [WORD_BITS-1:0]     lim;
    logic [WORD_BITS-1:0]     mag;
    logic                     last_bit;

    assign a_mag = a[OP_W-1] ? OP_W'(-a) : OP_W'(a);
    assign b_mag = b[OP_W-1] ? OP_W'(-b) : OP_W'(b);

    // Add the multiplicand into the upper half when the current bit is set.
    assign partial = {1'b0, acc_reg[2*OP_W-1:OP_W]} + {1'b0, (mb_reg[0] ? ma_reg : '0)};
    assign last_bit = (cnt_reg == CNT_W'(OP_W - 1));

    // The negative range reaches one step further than the positive one.
    assign scaled = acc_reg[2*OP_W-1:FRAC_BITS];
    assign lim    = {1'b0, {(WORD_BITS-1){1'b1}}} + {{(WORD_BITS-1){1'b0}}, neg_reg};
    assign mag    = (scaled > QW'(lim)) ? lim : scaled[WORD_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= run_reg && last_bit;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last_bit)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg  <= a_mag;
            mb_reg  <= b_mag;
            neg_reg <= a[OP_W-1] ^ b[OP_W-1];
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            acc_reg <= {partial, acc_reg[OP_W-1:1]};
            mb_reg  <= mb_reg >> 1;
        end
        if (fin_reg)
        begin
            result_reg <= neg_reg ? -$signed(mag) : $signed(mag);
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(fin_reg))
        else $error("multiplier finished without a rounding cycle");

    a_fin_not_running: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |-> !run_reg)
        else $error("multiplier rounding while still shifting");

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (!run_reg && !fin_reg))
        else $error("multiplier started while busy");

endmodule

`default_nettype wire

// ===== hdl/speed_governor_euler_step.sv =====
// Top level of the speed governor Euler step block.
// Instantiates sge_cfg_regs and sge_serial_mul; uses sge_pkg.
`default_nettype none

// Two-state steam turbine speed governor advanced one forward Euler step per
// item, in signed fixed point with FRAC_BITS fraction bits and WORD_BITS-wide
// internal states. An integrate item (cmd 0) carries speed, power setpoint and
// time step; the block forms the unlimited power derivative and the lag
// derivative from six coefficient products, integrates both states with two
// more, clamps the power at p_max or p_min and holds it there until the
// derivative turns back inside. An init item (cmd 1) loads init_power, clears
// the lag state and releases any hold. Each item gives exactly one result item.
// All eight products go one after another through a single bit-serial
// multiplier that retires one multiplier bit per cycle over max(WORD_BITS, 32)
// bits, and each product passes through issue, the shifting of those bits,
// rounding and hand-back; an init item goes straight to its result.
// One item is in work at a time; the next item is accepted once the
// result is placed in the output register, even while that result waits.
// Configuration registers may be written only while no item is in work.
module speed_governor_euler_step #(
    parameter int FRAC_BITS = 20,
    parameter int WORD_BITS = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               step_valid,
    output logic                                    step_stall,
    input  sge_pkg::step_item_t                     step_item,
    output logic                                    result_valid,
    input  wire logic                               result_stall,
    output sge_pkg::result_item_t                   result_item,
    input  wire logic                               cfg_write,
    input  wire logic [sge_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [sge_pkg::FIELD_BITS-1:0]     cfg_data
);
    import sge_pkg::*;

    // Multiplier operands are wide enough for both the 32-bit coefficients and
    // the internal words; SW holds any sum of four products before saturation.
    localparam int OW = (WORD_BITS > FIELD_BITS) ? WORD_BITS : FIELD_BITS;
    localparam int SW = OW + 3;

    // Saturate a wide signed value to the internal word range.
    function automatic logic signed [WORD_BITS-1:0] sat_w(input logic signed [SW-1:0] v);
        logic [SW-WORD_BITS:0] hi_bits;
        logic signed [WORD_BITS-1:0] r;
        hi_bits = v[SW-1:WORD_BITS-1];
        if ((&hi_bits) || !(|hi_bits))
        begin
            r = v[WORD_BITS-1:0];
        end
        else if (v[SW-1])
        begin
            r = {1'b1, {(WORD_BITS-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(WORD_BITS-1){1'b1}}};
        end
        return r;
    endfunction

    // Saturate a wide signed value to the 32-bit field range.
    function automatic logic signed [FIELD_BITS-1:0] sat_f(input logic signed [SW-1:0] v);
        logic [SW-FIELD_BITS:0] hi_bits;
        logic signed [FIELD_BITS-1:0] r;
        hi_bits = v[SW-1:FIELD_BITS-1];
        if ((&hi_bits) || !(|hi_bits))
        begin
            r = v[FIELD_BITS-1:0];
        end
        else if (v[SW-1])
        begin
            r = {1'b1, {(FIELD_BITS-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(FIELD_BITS-1){1'b1}}};
        end
        return r;
    endfunction

    cfg_t cfg;

    state_t state_reg, state_next;
    op_t    op_reg;

    // Governor state.
    logic signed [WORD_BITS-1:0] power_reg;
    logic signed [WORD_BITS-1:0] lag_reg;
    logic                        limited_reg, limited_next;
    logic                        high_reg, high_next;

    // Per-item working values.
    logic signed [WORD_BITS-1:0] pset_reg;
    logic signed [WORD_BITS-1:0] dt_reg;
    logic signed [WORD_BITS-1:0] err_reg;
    logic signed [WORD_BITS-1:0] dpu_reg;
    logic signed [WORD_BITS-1:0] dx_reg;
    logic signed [WORD_BITS-1:0] dp_reg;
    logic signed [SW-1:0]        acc_reg;

    logic                        result_valid_reg, result_valid_next;
    result_item_t                result_reg;

    logic                        step_accept;
    logic                        result_load;
    logic                        mul_start;
    logic                        mul_done;
    logic signed [WORD_BITS-1:0] mul_result;
    logic signed [OW-1:0]        mul_a;
    logic signed [OW-1:0]        mul_b;

    logic signed [WORD_BITS-1:0] speed_sat;
    logic signed [SW-1:0]        err_wide;
    logic signed [SW-1:0]        prod_ext;
    logic signed [SW-1:0]        acc_sum;
    logic signed [WORD_BITS-1:0] sum_sat;
    logic                        release_hold;
    logic                        above_max;
    logic                        below_min;

    sge_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sge_serial_mul #(
        .OP_W      (OW),
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .result (mul_result)
    );

    // Speed error against nominal 1.0, computed wide and then saturated.
    assign speed_sat = sat_w(SW'(step_item.speed));
    assign err_wide  = SW'(speed_sat) - (SW'(1) <<< FRAC_BITS);

    // Operand selection for the product now being issued.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op_reg)
            OP_PSET:
            begin
                mul_a = OW'(cfg.inv_t3);
                mul_b = OW'(pset_reg);
            end
            OP_PWR:
            begin
                mul_a = OW'(cfg.inv_t3);
                mul_b = OW'(power_reg);
            end
            OP_LAG:
            begin
                mul_a = OW'(cfg.k_over_t3);
                mul_b = OW'(lag_reg);
            end
            OP_ERR:
            begin
                mul_a = OW'(cfg.omega_gain);
                mul_b = OW'(err_reg);
            end
            OP_LAG_ERR:
            begin
                mul_a = OW'(cfg.lag_gain);
                mul_b = OW'(err_reg);
            end
            OP_LAG_DECAY:
            begin
                mul_a = OW'(cfg.inv_t1);
                mul_b = OW'(lag_reg);
            end
            OP_DP:
            begin
                mul_a = OW'(dt_reg);
                mul_b = OW'(dp_reg);
            end
            OP_DX:
            begin
                mul_a = OW'(dt_reg);
                mul_b = OW'(dx_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Fold each finished product into the running sum. The power derivative
    // sums four terms and the lag derivative two; the last two products are
    // added to the states they integrate.
    assign prod_ext = SW'(mul_result);

    always_comb
    begin
        case (op_reg) inside
            OP_PSET, OP_LAG_ERR:           acc_sum = prod_ext;
            OP_PWR, OP_LAG, OP_ERR:        acc_sum = acc_reg - prod_ext;
            OP_LAG_DECAY:                  acc_sum = acc_reg - prod_ext;
            OP_DP:                         acc_sum = SW'(power_reg) + prod_ext;
            OP_DX:                         acc_sum = SW'(lag_reg) + prod_ext;
            default:                       acc_sum = prod_ext;
        endcase
    end

    assign sum_sat = sat_w(acc_sum);

    // A hold ends when the unlimited derivative points back inside the range;
    // a derivative of exactly zero keeps the hold.
    assign release_hold = limited_reg &&
                          ((high_reg && (dpu_reg < 0)) || (!high_reg && (dpu_reg > 0)));

    // The upper limit is tested first, so it wins if the limits cross.
    assign above_max = $signed(OW'(power_reg)) > $signed(OW'(cfg.p_max));
    assign below_min = $signed(OW'(power_reg)) < $signed(OW'(cfg.p_min));

    always_comb
    begin
        limited_next = limited_reg;
        high_next    = high_reg;
        if (step_accept && step_item.cmd)
        begin
            limited_next = 1'b0;
            high_next    = 1'b0;
        end
        else if ((state_reg == ST_WAIT) && mul_done && (op_reg == OP_LAG_DECAY) &&
                 release_hold)
        begin
            limited_next = 1'b0;
            high_next    = 1'b0;
        end
        else if ((state_reg == ST_CLAMP) && !limited_reg)
        begin
            if (above_max)
            begin
                limited_next = 1'b1;
                high_next    = 1'b1;
            end
            else if (below_min)
            begin
                limited_next = 1'b1;
                high_next    = 1'b0;
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (step_valid)
                begin
                    state_next = step_item.cmd ? ST_DONE : ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = (op_reg == OP_DX) ? ST_CLAMP : ST_ISSUE;
                end
            end
            ST_CLAMP:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State machine outputs.
    always_comb
    begin
        step_stall  = 1'b1;
        mul_start   = 1'b0;
        result_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:  step_stall  = 1'b0;
            ST_ISSUE: mul_start   = 1'b1;
            ST_WAIT:  ;
            ST_CLAMP: ;
            ST_DONE:  result_load = !result_valid_reg || !result_stall;
            default:  ;
        endcase
    end

    assign step_accept = step_valid && !step_stall;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (result_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            op_reg           <= OP_PSET;
            power_reg        <= '0;
            lag_reg          <= '0;
            limited_reg      <= 1'b0;
            high_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            limited_reg      <= limited_next;
            high_reg         <= high_next;
            result_valid_reg <= result_valid_next;

            if (step_accept)
            begin
                op_reg <= OP_PSET;
                if (step_item.cmd)
                begin
                    power_reg <= sat_w(SW'(step_item.init_power));
                    lag_reg   <= '0;
                end
            end
            else if ((state_reg == ST_WAIT) && mul_done)
            begin
                op_reg <= op_t'(3'(op_reg + 3'd1));
                if (op_reg == OP_DP)
                begin
                    power_reg <= sum_sat;
                end
                if (op_reg == OP_DX)
                begin
                    lag_reg <= sum_sat;
                end
            end
            else if ((state_reg == ST_CLAMP) && !limited_reg)
            begin
                // A clamped power stays frozen at this value while held.
                if (above_max)
                begin
                    power_reg <= sat_w(SW'(cfg.p_max));
                end
                else if (below_min)
                begin
                    power_reg <= sat_w(SW'(cfg.p_min));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_accept)
        begin
            pset_reg <= sat_w(SW'(step_item.power_setpoint));
            dt_reg   <= sat_w(SW'($signed({1'b0, step_item.step_time})));
            err_reg  <= sat_w(err_wide);
        end
        if ((state_reg == ST_WAIT) && mul_done)
        begin
            acc_reg <= acc_sum;
            if (op_reg == OP_ERR)
            begin
                dpu_reg <= sum_sat;
            end
            if (op_reg == OP_LAG_DECAY)
            begin
                dx_reg <= sum_sat;
                // The step that releases a hold already integrates with the
                // unlimited derivative.
                dp_reg <= (limited_reg && !release_hold) ? '0 : dpu_reg;
            end
        end
        if (result_load)
        begin
            result_reg.mech_power    <= sat_f(SW'(power_reg));
            result_reg.lag_state     <= sat_f(SW'(lag_reg));
            result_reg.limited       <= limited_reg;
            result_reg.at_high_limit <= high_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;

    a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_WAIT))
        else $error("product finished outside the wait state");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised without a finished item");

    a_high_implies_held: assert property (@(posedge clk) disable iff (!rst_n)
        high_reg |-> limited_reg)
        else $error("upper limit flag set while power is not held");

endmodule

`default_nettype wire
